/* hdl/stt_pkg.sv */
// Shared types and constants for the software timer slot table.
// No dependencies; compile first.
package stt_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int TICK_W      = 16;
  localparam int HND_W       = 8;
  localparam int TAG_W       = 16;
  localparam int SLOT_W      = 3;
  localparam int POS_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_CREATE = 1'b1
  } stt_op_e;

  typedef enum logic {
    KIND_CREATE = 1'b0,
    KIND_EXPIRE = 1'b1
  } stt_kind_e;

  typedef struct packed {
    logic              adv;
    logic              is_create;
    logic [TICK_W-1:0] count;
    logic [TICK_W-1:0] timeout;
    logic              repeat_req;
    logic [HND_W-1:0]  handler;
    logic [TAG_W-1:0]  tag;
  } stt_ctrl_t;

  typedef struct packed {
    logic             token;
    logic             hit;
    logic             free;
    logic [HND_W-1:0] handler;
    logic [TAG_W-1:0] tag;
  } stt_cell_st_t;

endpackage

/* hdl/stt_if.sv */
// Valid/ready channel interfaces for the timer table request and result beats.
// Depends on stt_pkg for field widths.
interface stt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [stt_pkg::TICK_W-1:0] timeout;
  logic                       repeat_req;
  logic [stt_pkg::HND_W-1:0]  handler_id;
  logic [stt_pkg::TAG_W-1:0]  tag;

  modport source (output valid, opcode, timeout, repeat_req, handler_id, tag, input ready);
  modport sink   (input valid, opcode, timeout, repeat_req, handler_id, tag, output ready);
endinterface

interface stt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [stt_pkg::SLOT_W-1:0] slot;
  logic                       ok;
  logic [stt_pkg::HND_W-1:0]  fired_handler;
  logic [stt_pkg::TAG_W-1:0]  fired_tag;
  logic                       last;

  modport source (output valid, kind, slot, ok, fired_handler, fired_tag, last, input ready);
  modport sink   (input valid, kind, slot, ok, fired_handler, fired_tag, last, output ready);
endinterface

/* hdl/stt_cell.sv */
// One timer slot: holds expiry, period, handler and tag, and passes the scan token on.
// Depends on stt_pkg.
module stt_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stt_pkg::stt_ctrl_t    ctrl_i,
  input  logic                  token_i,
  output logic                  token_o,
  output stt_pkg::stt_cell_st_t st_o
);
  import stt_pkg::*;

  logic              token_q;
  logic              active_q;
  logic [TICK_W-1:0] expiry_q;
  logic [TICK_W-1:0] period_q;
  logic [HND_W-1:0]  handler_q;
  logic [TAG_W-1:0]  tag_q;
  logic              hit;
  logic              claim;
  logic              fire;

  assign hit   = active_q && (expiry_q == ctrl_i.count);
  assign claim = ctrl_i.adv && token_q && ctrl_i.is_create && !active_q;
  assign fire  = ctrl_i.adv && token_q && !ctrl_i.is_create && hit;

  // stop the token at the slot that a create claims
  assign token_o = token_q && !(ctrl_i.is_create && !active_q);

  assign st_o.token   = token_q;
  assign st_o.hit     = hit;
  assign st_o.free    = !active_q;
  assign st_o.handler = handler_q;
  assign st_o.tag     = tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q  <= 1'b0;
      active_q <= 1'b0;
    end else begin
      if (ctrl_i.adv) begin
        token_q <= token_i;
      end
      if (claim) begin
        active_q <= 1'b1;
      end else if (fire && (period_q == '0)) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (claim) begin
      expiry_q  <= ctrl_i.count + ctrl_i.timeout;
      period_q  <= ctrl_i.repeat_req ? ctrl_i.timeout : '0;
      handler_q <= ctrl_i.handler;
      tag_q     <= ctrl_i.tag;
    end else if (fire) begin
      expiry_q <= expiry_q + period_q;
    end
  end

endmodule

/* hdl/software_timer_table.sv */
// Top level of the software timer slot table: request decode, scan control, result register.
// Depends on stt_pkg, stt_if and stt_cell.
//
//   channel  dir  beat
//   in_i     in   opcode, timeout, repeat_req, handler_id, tag
//   out_o    out  kind, slot, ok, fired_handler, fired_tag, last
//
// During a tick the token walks the cell row one slot per cycle while the result register is free.
// A create stops at the first free slot, or at the last slot when no slot is free.
// Reset clears all slots and the tick counter; no clearing pass is needed.
// A stalled result register holds the token in place until the beat is taken.
module software_timer_table (
  input  logic clk_i,
  input  logic rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);
  import stt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e            state_q, state_d;
  stt_op_e           op_q;
  logic [TICK_W-1:0] count_q;
  logic [TICK_W-1:0] timeout_q;
  logic              repeat_q;
  logic [HND_W-1:0]  handler_q;
  logic [TAG_W-1:0]  tag_q;
  logic [POS_W-1:0]  pos_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              start;
  logic              out_free;
  logic              scan_adv;
  logic              at_end;
  stt_ctrl_t         ctrl;
  stt_cell_st_t      cell_st [NUM_SLOTS];
  logic [NUM_SLOTS:0]   tok_chain;
  logic [NUM_SLOTS-1:0] tok_vec;
  logic [NUM_SLOTS-1:0] hit_vec;
  logic [NUM_SLOTS-1:0] free_vec;
  logic [NUM_SLOTS-1:0] upto_mask;
  logic              cur_hit;
  logic              cur_free;
  logic              later_hit;
  logic [HND_W-1:0]  cur_handler;
  logic [TAG_W-1:0]  cur_tag;

  logic              emit;
  logic              done;
  stt_kind_e         e_kind;
  logic [SLOT_W-1:0] e_slot;
  logic              e_ok;
  logic [HND_W-1:0]  e_hnd;
  logic [TAG_W-1:0]  e_tag;
  logic              e_last;

  logic              out_valid_q;
  stt_kind_e         out_kind_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_ok_q;
  logic [HND_W-1:0]  out_hnd_q;
  logic [TAG_W-1:0]  out_tag_q;
  logic              out_last_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign start      = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign scan_adv   = (state_q == ST_SCAN) && out_free;
  assign at_end     = (pos_q == POS_W'(NUM_SLOTS - 1));

  assign ctrl.adv        = start || scan_adv;
  assign ctrl.is_create  = (op_q == OP_CREATE);
  assign ctrl.count      = count_q;
  assign ctrl.timeout    = timeout_q;
  assign ctrl.repeat_req = repeat_q;
  assign ctrl.handler    = handler_q;
  assign ctrl.tag        = tag_q;

  assign tok_chain[0] = start;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    stt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .token_i (tok_chain[g]),
      .token_o (tok_chain[g+1]),
      .st_o    (cell_st[g])
    );
    assign tok_vec[g]  = cell_st[g].token;
    assign hit_vec[g]  = cell_st[g].hit;
    assign free_vec[g] = cell_st[g].free;
  end

  assign cur_hit   = |(hit_vec & tok_vec);
  assign cur_free  = |(free_vec & tok_vec);
  assign upto_mask = (tok_vec << 1) - NUM_SLOTS'(1);
  assign later_hit = |(hit_vec & ~upto_mask);

  always_comb begin
    cur_handler = '0;
    cur_tag     = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tok_vec[i]) begin
        cur_handler = cur_handler | cell_st[i].handler;
        cur_tag     = cur_tag | cell_st[i].tag;
      end
    end
  end

  always_comb begin
    emit   = 1'b0;
    done   = 1'b0;
    e_kind = KIND_CREATE;
    e_slot = '0;
    e_ok   = 1'b0;
    e_hnd  = '0;
    e_tag  = '0;
    e_last = 1'b1;
    if (scan_adv) begin
      if (op_q == OP_CREATE) begin
        if (cur_free) begin
          emit   = 1'b1;
          done   = 1'b1;
          e_slot = SLOT_W'(pos_q);
          e_ok   = 1'b1;
        end else if (at_end) begin
          emit = 1'b1;
          done = 1'b1;
        end
      end else begin
        if (cur_hit && (cnt_q < CNT_W'(MAX_RESULTS))) begin
          emit   = 1'b1;
          e_kind = KIND_EXPIRE;
          e_slot = SLOT_W'(pos_q);
          e_ok   = 1'b1;
          e_hnd  = cur_handler;
          e_tag  = cur_tag;
          e_last = (cnt_q == CNT_W'(MAX_RESULTS - 1)) || !later_hit;
        end
        if (at_end) begin
          done = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_SCAN;
      ST_SCAN: if (done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      op_q        <= OP_TICK;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start) begin
        op_q  <= stt_op_e'(in_i.opcode);
        pos_q <= '0;
        cnt_q <= '0;
        if (in_i.opcode == OP_TICK) begin
          count_q <= count_q + TICK_W'(1);
        end
      end else if (scan_adv) begin
        if (!at_end) begin
          pos_q <= pos_q + POS_W'(1);
        end
        if (emit && (op_q == OP_TICK)) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      timeout_q <= in_i.timeout;
      repeat_q  <= in_i.repeat_req;
      handler_q <= in_i.handler_id;
      tag_q     <= in_i.tag;
    end
    if (emit) begin
      out_kind_q <= e_kind;
      out_slot_q <= e_slot;
      out_ok_q   <= e_ok;
      out_hnd_q  <= e_hnd;
      out_tag_q  <= e_tag;
      out_last_q <= e_last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_kind_q;
  assign out_o.slot          = out_slot_q;
  assign out_o.ok            = out_ok_q;
  assign out_o.fired_handler = out_hnd_q;
  assign out_o.fired_tag     = out_tag_q;
  assign out_o.last          = out_last_q;

  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("scan token held by more than one slot");

  a_idle_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (tok_vec == '0))
    else $error("scan token present while idle");

  a_token_at_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && tok_vec != '0) |-> tok_vec[pos_q])
    else $error("scan token and slot position disagree");

  a_exit_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_chain[NUM_SLOTS] |-> at_end)
    else $error("token left the row before the last slot");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("expiry count past limit");

endmodule

/* dv/software_timer_table_tb.sv */
// Self-checking testbench for software_timer_table: creates timers, advances ticks,
// and checks every create answer and expiry beat against a timer table model of its own.
// Depends on stt_pkg, stt_if and the software_timer_table RTL.
module software_timer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  typedef struct packed {
    stt_op_e           op;
    logic [TICK_W-1:0] timeout;
    logic              repeat_req;
    logic [HND_W-1:0]  handler_id;
    logic [TAG_W-1:0]  tag;
  } request_t;

  typedef struct packed {
    stt_kind_e         kind;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic [HND_W-1:0]  handler;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } answer_t;

  class timer_board;
    logic              active  [NUM_SLOTS];
    logic [TICK_W-1:0] expiry  [NUM_SLOTS];
    logic [TICK_W-1:0] period  [NUM_SLOTS];
    logic [HND_W-1:0]  handler [NUM_SLOTS];
    logic [TAG_W-1:0]  tag_val [NUM_SLOTS];
    logic [TICK_W-1:0] ticks;
    answer_t           owed[$];
    int                mismatches;
    int                requests;
    int                creates_ok;
    int                creates_full;
    int                expiries;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        active[i]  = 1'b0;
        expiry[i]  = '0;
        period[i]  = '0;
        handler[i] = '0;
        tag_val[i] = '0;
      end
      ticks        = '0;
      mismatches   = 0;
      requests     = 0;
      creates_ok   = 0;
      creates_full = 0;
      expiries     = 0;
    endfunction

    // Slots that stay occupied for a long time: periodic, or far from expiry.
    function int long_lived();
      int k;
      k = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (active[i] && (period[i] != '0 || TICK_W'(expiry[i] - ticks - 1'b1) >= 16'd64)) begin
          k++;
        end
      end
      return k;
    endfunction

    function void note_request(request_t req);
      answer_t a;
      bit      placed;
      int      hits;
      int      n;
      requests++;
      if (req.op == OP_CREATE) begin
        a      = '0;
        a.kind = KIND_CREATE;
        a.last = 1'b1;
        placed = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!placed && !active[i]) begin
            active[i]  = 1'b1;
            expiry[i]  = TICK_W'(ticks + req.timeout);
            period[i]  = req.repeat_req ? req.timeout : '0;
            handler[i] = req.handler_id;
            tag_val[i] = req.tag;
            a.slot     = SLOT_W'(i);
            a.ok       = 1'b1;
            placed     = 1'b1;
          end
        end
        if (placed) creates_ok++;
        else creates_full++;
        owed.push_back(a);
      end else begin
        ticks = ticks + 1'b1;
        hits  = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (active[i] && expiry[i] == ticks) hits++;
        end
        if (hits > MAX_RESULTS) hits = MAX_RESULTS;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (active[i] && expiry[i] == ticks) begin
            if (n < hits) begin
              a         = '0;
              a.kind    = KIND_EXPIRE;
              a.slot    = SLOT_W'(i);
              a.ok      = 1'b1;
              a.handler = handler[i];
              a.tag     = tag_val[i];
              a.last    = (n == hits - 1);
              owed.push_back(a);
              expiries++;
              n++;
            end
            if (period[i] != '0) expiry[i] = TICK_W'(expiry[i] + period[i]);
            else active[i] = 1'b0;
          end
        end
      end
    endfunction

    function void flag_field(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got kind=%0d slot=%0d ok=%0d handler=0x%0h tag=0x%0h last=%0d",
                 $time, got.kind, got.slot, got.ok, got.handler, got.tag, got.last);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      if (got.kind != want.kind) flag_field("kind", want.kind, got.kind);
      if (got.slot != want.slot) flag_field("slot", want.slot, got.slot);
      if (got.ok != want.ok) flag_field("ok", want.ok, got.ok);
      if (got.handler != want.handler) flag_field("fired_handler", want.handler, got.handler);
      if (got.tag != want.tag) flag_field("fired_tag", want.tag, got.tag);
      if (got.last != want.last) flag_field("last", want.last, got.last);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  bit         calm;
  int         beats_taken;
  timer_board board = new();

  stt_in_if  in_bus ();
  stt_out_if out_bus ();

  software_timer_table uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out with %0d results outstanding", $time, board.owed.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic request_t make_create(logic [TICK_W-1:0] timeout, logic repeat_req,
                                           logic [HND_W-1:0] handler_id, logic [TAG_W-1:0] tag);
    request_t req;
    req.op         = OP_CREATE;
    req.timeout    = timeout;
    req.repeat_req = repeat_req;
    req.handler_id = handler_id;
    req.tag        = tag;
    return req;
  endfunction

  function automatic request_t make_tick();
    request_t req;
    req.op         = OP_TICK;
    req.timeout    = TICK_W'($urandom);
    req.repeat_req = 1'($urandom);
    req.handler_id = HND_W'($urandom);
    req.tag        = TAG_W'($urandom);
    return req;
  endfunction

  // Keep most timers short-lived so slots keep turning over.
  function automatic request_t random_create();
    request_t    req;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    req  = make_create(TICK_W'($urandom_range(1, 12)), 1'b0, HND_W'($urandom), TAG_W'($urandom));
    if (board.long_lived() < 4) begin
      if (roll >= 95) begin
        req.timeout    = '0;
        req.repeat_req = 1'($urandom);
      end else if (roll >= 85) begin
        req.timeout    = TICK_W'($urandom);
        req.repeat_req = 1'($urandom);
      end else if (roll >= 70) begin
        req.timeout    = TICK_W'($urandom_range(1, 16));
        req.repeat_req = 1'b1;
      end
    end
    return req;
  endfunction

  task automatic send_beat(input request_t req);
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= req.op;
    in_bus.timeout    <= req.timeout;
    in_bus.repeat_req <= req.repeat_req;
    in_bus.handler_id <= req.handler_id;
    in_bus.tag        <= req.tag;
    do @(posedge clk); while (!in_bus.ready);
    board.note_request(req);
  endtask

  task automatic hold_off(input int cycles);
    in_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (board.owed.size() != 0);
  endtask

  initial begin : result_side
    answer_t got;
    int      stall_left;
    bit      held_long;
    stall_left    = 0;
    held_long     = 1'b0;
    beats_taken   = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got.kind    = stt_kind_e'(out_bus.kind);
        got.slot    = out_bus.slot;
        got.ok      = out_bus.ok;
        got.handler = out_bus.fired_handler;
        got.tag     = out_bus.fired_tag;
        got.last    = out_bus.last;
        board.check_answer(got);
        beats_taken++;
      end
      if (!held_long && beats_taken == 40) begin
        held_long  = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : request_side
    request_t req;
    calm              = 1'b0;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.opcode     <= OP_TICK;
    in_bus.timeout    <= '0;
    in_bus.repeat_req <= 1'b0;
    in_bus.handler_id <= '0;
    in_bus.tag        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every slot with the same expiry, overflow the table, then fire all at once.
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_beat(make_create(16'd1, 1'b0, HND_W'(i * 37 + 3), TAG_W'(i * 4099 + 1)));
    end
    send_beat(make_create(16'd5, 1'b1, 8'h42, 16'h4242));
    send_beat(make_tick());

    // Field extremes, zero timeout, periodic reload and a quiet tick.
    send_beat(make_create(16'd0, 1'b1, 8'hFF, 16'hFFFF));
    send_beat(make_create(16'hFFFF, 1'b0, 8'h00, 16'h0000));
    send_beat(make_create(16'd1, 1'b0, 8'hA5, 16'h5A5A));
    send_beat(make_create(16'd2, 1'b1, 8'h5A, 16'hA5A5));
    send_beat(make_create(16'd2, 1'b0, 8'hFE, 16'hFFFE));
    repeat (4) send_beat(make_tick());
    drain_results();

    for (int n = 0; n < 280; n++) begin
      if (n == 140) drain_results();
      if (n == 230) calm = 1'b1;
      if ($urandom_range(0, 99) < 55) req = make_tick();
      else req = random_create();
      send_beat(req);
      if (!calm && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 9));
    end
    drain_results();
    repeat (40) @(posedge clk);

    $display("Covered %0d requests over %0d ticks: %0d timers created, %0d refused on a full table,",
             board.requests, board.ticks, board.creates_ok, board.creates_full);
    $display("%0d expiries predicted, %0d result beats checked, %0d mismatches.",
             board.expiries, beats_taken, board.mismatches);
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
